// ----- rtl/core/ffba_pkg.sv -----
`default_nettype none
package ffba_pkg;

	localparam int HEAP_BLOCKS_DEF = 4096;
	localparam int SIZE_W          = 12;
	localparam int ADDR_W          = 12;
	localparam int STATUS_W        = 2;
	localparam int CFG_W           = 13;
	localparam logic [CFG_W-1:0] HB_RESET = 13'd4096;

	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_NULL  = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_A_RD,
		S_A_CHK,
		S_A_SPLIT,
		S_F_RD,
		S_F_CHK,
		S_L_A,
		S_L_B,
		S_M1_RD,
		S_M1_CHK,
		S_M2_RD,
		S_M2_CHK,
		S_M3_RD,
		S_M3_CHK,
		S_SUM_INIT,
		S_SUM_RD,
		S_SUM_CHK,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/core/ffba_req_if.sv -----
`default_nettype none
interface ffba_req_if import ffba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [SIZE_W-1:0] size_blocks;
	logic [ADDR_W-1:0] address_block;

	modport source (output valid, func, size_blocks, address_block, input ready);
	modport sink (input valid, func, size_blocks, address_block, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ffba_rsp_if.sv -----
`default_nettype none
interface ffba_rsp_if import ffba_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   result_block;
	logic [SIZE_W-1:0]   free_blocks;

	modport source (output valid, status, result_block, free_blocks, input ready);
	modport sink (input valid, status, result_block, free_blocks, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ffba_cfg_if.sv -----
`default_nettype none
interface ffba_cfg_if import ffba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ffba_ram.sv -----
`default_nettype none
module ffba_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/core/first_fit_block_allocator_top.sv -----
// First-fit block allocator with coalescing over an address-ordered free list.
// Channels: req (func, size_blocks, address_block), rsp (status, result_block,
// free_blocks), cfg (heap_blocks write). Each transfer completes when valid and
// ready are both high at a rising clock edge.
// One request at a time. An allocate visits free segments in list order up to
// the fit, plus a split state when it splits; a free walks the segments before
// the insert point, then links and merges. Every request then walks the whole
// free list to total the free blocks. The three link and size memories share a
// single read port, so every segment visited needs a read and a check state.
// Reset (and every cfg write) sets one free segment of heap_blocks-1 blocks at
// header 0 (heap_blocks held in 2..HEAP_BLOCKS); other entries stay undefined.
// The result sits in an output register; a new request is taken while it waits,
// and that request holds in its final state until rsp is free again.
`default_nettype none
module first_fit_block_allocator_top import ffba_pkg::*; #(
	parameter int HEAP_BLOCKS = HEAP_BLOCKS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ffba_req_if.sink   req,
	ffba_rsp_if.source rsp,
	ffba_cfg_if.sink   cfg
);
	localparam int IW = $clog2(HEAP_BLOCKS);
	localparam int LW = IW + 1;
	localparam int CW = ((LW > 13) ? LW : 13) + 2;
	localparam logic [LW-1:0] NIL = LW'(HEAP_BLOCKS);
	localparam logic [CW-1:0] HBW = CW'(HEAP_BLOCKS);
	localparam logic [LW-1:0] LAST_STEP = LW'(HEAP_BLOCKS - 1);

	function automatic logic node_w(logic [CW-1:0] x);
		return x < HBW;
	endfunction

	function automatic logic node(logic [LW-1:0] x);
		return CW'(x) < HBW;
	endfunction

	function automatic logic [LW-1:0] nrm(logic [LW-1:0] x);
		return node(x) ? x : NIL;
	endfunction

	state_t state_q, state_d;

	logic [CFG_W-1:0]  hb_q, hb_d;
	logic [LW-1:0]     head_q, head_d;
	logic [SIZE_W-1:0] want_q, want_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [LW-1:0]     cur_q, cur_d;
	logic [LW-1:0]     h_q, h_d;
	logic [SIZE_W-1:0] hs_q, hs_d;
	logic [LW-1:0]     n_q, n_d;
	logic [LW-1:0]     pa_q, pa_d;
	logic [LW-1:0]     aux_q, aux_d;
	logic [LW-1:0]     steps_q, steps_d;
	logic              last_q, last_d;
	logic [SIZE_W-1:0] total_q, total_d;
	status_t           status_q, status_d;
	logic [ADDR_W-1:0] result_q, result_d;

	logic                rsp_v_q;
	logic [STATUS_W-1:0] o_status_q;
	logic [ADDR_W-1:0]   o_result_q;
	logic [SIZE_W-1:0]   o_free_q;
	logic                load_out;

	logic              sz_we, nx_we, pv_we;
	logic [IW-1:0]     sz_wa, nx_wa, pv_wa, rd_addr;
	logic [SIZE_W-1:0] sz_wd, rd_sz;
	logic [LW-1:0]     nx_wd, pv_wd, rd_nx, rd_pv;

	logic [CW-1:0] rb, hbw_in, rest, sum_a, sum_b;
	logic [LW-1:0] nx_r, pv_r;
	logic [ADDR_W-1:0] h_in;

	ffba_ram #(.WIDTH(SIZE_W), .DEPTH(HEAP_BLOCKS)) u_size (
		.clk(clk), .we(sz_we), .waddr(sz_wa), .wdata(sz_wd), .raddr(rd_addr), .rdata(rd_sz)
	);
	ffba_ram #(.WIDTH(LW), .DEPTH(HEAP_BLOCKS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(rd_addr), .rdata(rd_nx)
	);
	ffba_ram #(.WIDTH(LW), .DEPTH(HEAP_BLOCKS)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(rd_addr), .rdata(rd_pv)
	);

	always_comb begin
		hbw_in = CW'(hb_q);
		if (hbw_in < CW'(2)) begin
			rb = CW'(2);
		end else if (hbw_in > HBW) begin
			rb = HBW;
		end else begin
			rb = hbw_in;
		end
	end

	assign req.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg.ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		hb_d     = hb_q;
		head_d   = head_q;
		want_d   = want_q;
		addr_d   = addr_q;
		cur_d    = cur_q;
		h_d      = h_q;
		hs_d     = hs_q;
		n_d      = n_q;
		pa_d     = pa_q;
		aux_d    = aux_q;
		steps_d  = steps_q;
		last_d   = last_q;
		total_d  = total_q;
		status_d = status_q;
		result_d = result_q;
		load_out = 1'b0;
		sz_we = 1'b0; sz_wa = '0; sz_wd = '0;
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
		rd_addr = IW'(cur_q);
		nx_r  = nrm(rd_nx);
		pv_r  = nrm(rd_pv);
		rest  = CW'(cur_q) + CW'(want_q) + CW'(1);
		sum_a = '0;
		sum_b = '0;
		h_in  = req.address_block - ADDR_W'(1);

		case (state_q)
			S_INIT: begin
				sz_we = 1'b1; sz_wa = '0; sz_wd = SIZE_W'(rb - CW'(1));
				nx_we = 1'b1; nx_wa = '0; nx_wd = NIL;
				pv_we = 1'b1; pv_wa = '0; pv_wd = NIL;
				head_d  = '0;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cfg.valid) begin
					hb_d    = cfg.data;
					state_d = S_INIT;
				end else if (req.valid) begin
					want_d   = req.size_blocks;
					addr_d   = req.address_block;
					status_d = ST_OK;
					result_d = '0;
					steps_d  = '0;
					last_d   = 1'b0;
					cur_d    = head_q;
					if (req.func == FN_ALLOC) begin
						if (node(head_q)) begin
							state_d = S_A_RD;
						end else begin
							status_d = ST_NOFIT;
							state_d  = S_SUM_INIT;
						end
					end else if (req.address_block == '0) begin
						status_d = ST_NULL;
						state_d  = S_SUM_INIT;
					end else if (CW'(h_in) >= rb) begin
						state_d = S_SUM_INIT;
					end else begin
						h_d = LW'(h_in);
						if (!node(head_q) || CW'(head_q) >= CW'(req.address_block)) begin
							n_d     = head_q;
							pa_d    = NIL;
							head_d  = LW'(h_in);
							state_d = S_L_A;
						end else begin
							state_d = S_F_RD;
						end
					end
				end
			end
			S_A_RD: begin
				state_d = S_A_CHK;
			end
			S_A_CHK: begin
				if (CW'(rd_sz) > CW'(want_q) + CW'(1)) begin
					if (node_w(rest)) begin
						sz_we = 1'b1; sz_wa = IW'(rest); sz_wd = rd_sz - want_q - SIZE_W'(1);
						nx_we = 1'b1; nx_wa = IW'(rest); nx_wd = nx_r;
						pv_we = 1'b1; pv_wa = IW'(rest); pv_wd = pv_r;
					end
					aux_d = node_w(rest) ? LW'(rest) : NIL;
					n_d   = nx_r;
					pa_d  = pv_r;
					if (cur_q == head_q) begin
						head_d = node_w(rest) ? LW'(rest) : NIL;
					end
					result_d = ADDR_W'(CW'(cur_q) + CW'(1));
					state_d  = S_A_SPLIT;
				end else if (rd_sz >= want_q) begin
					if (node(pv_r)) begin
						nx_we = 1'b1; nx_wa = IW'(pv_r); nx_wd = nx_r;
					end
					if (node(nx_r)) begin
						pv_we = 1'b1; pv_wa = IW'(nx_r); pv_wd = pv_r;
					end
					if (cur_q == head_q) begin
						head_d = nx_r;
					end
					result_d = ADDR_W'(CW'(cur_q) + CW'(1));
					state_d  = S_SUM_INIT;
				end else if (!node(nx_r) || steps_q == LAST_STEP) begin
					status_d = ST_NOFIT;
					state_d  = S_SUM_INIT;
				end else begin
					cur_d   = nx_r;
					steps_d = steps_q + LW'(1);
					state_d = S_A_RD;
				end
			end
			S_A_SPLIT: begin
				if (node(n_q)) begin
					pv_we = 1'b1; pv_wa = IW'(n_q); pv_wd = aux_q;
				end
				if (node(pa_q)) begin
					nx_we = 1'b1; nx_wa = IW'(pa_q); nx_wd = aux_q;
				end
				sz_we = 1'b1; sz_wa = IW'(cur_q); sz_wd = want_q;
				state_d = S_SUM_INIT;
			end
			S_F_RD: begin
				state_d = S_F_CHK;
			end
			S_F_CHK: begin
				if (last_q || !node(nx_r) || CW'(nx_r) >= CW'(addr_q)) begin
					n_d     = nx_r;
					pa_d    = cur_q;
					state_d = S_L_A;
				end else begin
					cur_d   = nx_r;
					steps_d = steps_q + LW'(1);
					if (steps_q == LAST_STEP) begin
						last_d = 1'b1;
					end
					state_d = S_F_RD;
				end
			end
			S_L_A: begin
				nx_we = 1'b1; nx_wa = IW'(h_q); nx_wd = n_q;
				pv_we = 1'b1; pv_wa = IW'(h_q); pv_wd = pa_q;
				state_d = S_L_B;
			end
			S_L_B: begin
				if (node(n_q)) begin
					pv_we = 1'b1; pv_wa = IW'(n_q); pv_wd = h_q;
				end
				if (node(pa_q)) begin
					nx_we = 1'b1; nx_wa = IW'(pa_q); nx_wd = h_q;
				end
				state_d = S_M1_RD;
			end
			S_M1_RD: begin
				rd_addr = IW'(h_q);
				state_d = S_M1_CHK;
			end
			S_M1_CHK: begin
				pa_d    = pv_r;
				hs_d    = rd_sz;
				n_d     = nx_r;
				state_d = node(pv_r) ? S_M2_RD : S_M3_RD;
			end
			S_M2_RD: begin
				rd_addr = IW'(pa_q);
				state_d = S_M2_CHK;
			end
			S_M2_CHK: begin
				sum_a = CW'(pa_q) + CW'(rd_sz) + CW'(1);
				if (sum_a == CW'(h_q)) begin
					sz_we = 1'b1; sz_wa = IW'(pa_q); sz_wd = rd_sz + hs_q + SIZE_W'(1);
					nx_we = 1'b1; nx_wa = IW'(pa_q); nx_wd = n_q;
					if (node(n_q)) begin
						pv_we = 1'b1; pv_wa = IW'(n_q); pv_wd = pa_q;
					end
					h_d  = pa_q;
					hs_d = rd_sz + hs_q + SIZE_W'(1);
				end
				state_d = S_M3_RD;
			end
			S_M3_RD: begin
				rd_addr = IW'(n_q);
				state_d = node(n_q) ? S_M3_CHK : S_SUM_INIT;
			end
			S_M3_CHK: begin
				sum_b = CW'(h_q) + CW'(hs_q) + CW'(1);
				if (sum_b == CW'(n_q)) begin
					sz_we = 1'b1; sz_wa = IW'(h_q); sz_wd = hs_q + rd_sz + SIZE_W'(1);
					nx_we = 1'b1; nx_wa = IW'(h_q); nx_wd = nx_r;
					if (node(nx_r)) begin
						pv_we = 1'b1; pv_wa = IW'(nx_r); pv_wd = h_q;
					end
				end
				state_d = S_SUM_INIT;
			end
			S_SUM_INIT: begin
				cur_d   = head_q;
				total_d = '0;
				steps_d = '0;
				state_d = node(head_q) ? S_SUM_RD : S_DONE;
			end
			S_SUM_RD: begin
				state_d = S_SUM_CHK;
			end
			S_SUM_CHK: begin
				total_d = total_q + rd_sz;
				if (!node(nx_r) || steps_q == LAST_STEP) begin
					state_d = S_DONE;
				end else begin
					cur_d   = nx_r;
					steps_d = steps_q + LW'(1);
					state_d = S_SUM_RD;
				end
			end
			S_DONE: begin
				if (!rsp_v_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_q    <= HB_RESET;
			head_q  <= '0;
			steps_q <= '0;
			last_q  <= 1'b0;
		end else begin
			hb_q    <= hb_d;
			head_q  <= head_d;
			steps_q <= steps_d;
			last_q  <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		want_q   <= want_d;
		addr_q   <= addr_d;
		cur_q    <= cur_d;
		h_q      <= h_d;
		hs_q     <= hs_d;
		n_q      <= n_d;
		pa_q     <= pa_d;
		aux_q    <= aux_d;
		total_q  <= total_d;
		status_q <= status_d;
		result_q <= result_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (load_out) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			o_status_q <= status_q;
			o_result_q <= result_q;
			o_free_q   <= total_q;
		end
	end

	assign rsp.valid        = rsp_v_q;
	assign rsp.status       = o_status_q;
	assign rsp.result_block = o_result_q;
	assign rsp.free_blocks  = o_free_q;

	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q < LW'(HEAP_BLOCKS))
		else $error("walk counter past heap size");

	a_head_norm: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= NIL)
		else $error("list head not normalized");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_v_q && !rsp.ready) |=> (state_q == S_DONE))
		else $error("pending result overwritten");

	a_no_dual: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.valid && req.ready && cfg.valid && cfg.ready))
		else $error("request and config transfer at once");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_v_q && o_status_q != ST_OK) |-> (o_result_q == '0))
		else $error("failed request carries a block index");

endmodule
`default_nettype wire
